[rtl/assert_macros.svh]
// Assertion helpers included by matrix4_multiply_fixed.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/m4mf_pkg.sv]
package m4mf_pkg;

  // Matrix geometry
  localparam int DIM       = 4;
  localparam int CELLS     = DIM * DIM;
  localparam int IDX_W     = 4;
  localparam int SUB_W     = 2;
  localparam int PORT_W    = 32;
  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

  // Tag that travels down the cell chain with each partial sum
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

[rtl/m4mf_cell.sv]
// One multiply-accumulate cell of the chain. Cell k holds column k of the
// left matrix and row k of the right matrix, adds left[r][k]*right[k][c]
// to the partial sum arriving from its upstream neighbor, and hands the
// sum on through its product register and then its sum register.
module m4mf_cell #(
  parameter int CELL_K    = 0,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [m4mf_pkg::IDX_W-1:0]    wr_idx,
  input  logic [WORD_BITS-1:0]          wr_left,
  input  logic [WORD_BITS-1:0]          wr_right,
  input  m4mf_pkg::tag_t                tag_in,
  input  logic signed [2*WORD_BITS+1:0] sum_in,
  output m4mf_pkg::tag_t                tag_out,
  output logic signed [2*WORD_BITS+1:0] sum_out
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 2;
  localparam logic [m4mf_pkg::SUB_W-1:0] MY_K = m4mf_pkg::SUB_W'(CELL_K);

  logic signed [WORD_BITS-1:0] lcol_r [m4mf_pkg::DIM];
  logic signed [WORD_BITS-1:0] rrow_r [m4mf_pkg::DIM];

  logic                        vld_d_r, vld_r;
  logic [m4mf_pkg::IDX_W-1:0]  idx_d_r, idx_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [SW-1:0]  sum_d_r, sum_r, sum_nxt;
  logic [m4mf_pkg::SUB_W-1:0] row_sel, col_sel;

  // Element storage: left[r][k] lands at row r, right[k][c] at column c
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx[m4mf_pkg::SUB_W-1:0] == MY_K) begin
      lcol_r[wr_idx[m4mf_pkg::IDX_W-1:m4mf_pkg::SUB_W]] <= wr_left;
    end
    if (wr_en && wr_idx[m4mf_pkg::IDX_W-1:m4mf_pkg::SUB_W] == MY_K) begin
      rrow_r[wr_idx[m4mf_pkg::SUB_W-1:0]] <= wr_right;
    end
  end

  // Stage 1: pick operands for this word's row and column, multiply
  assign row_sel  = tag_in.idx[m4mf_pkg::IDX_W-1:m4mf_pkg::SUB_W];
  assign col_sel  = tag_in.idx[m4mf_pkg::SUB_W-1:0];
  assign prod_nxt = PW'(lcol_r[row_sel]) * PW'(rrow_r[col_sel]);

  // Stage 2: accumulate onto the upstream sum
  assign sum_nxt = sum_d_r + {{2{prod_r[PW-1]}}, prod_r};

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    sum_d_r <= sum_in;
    sum_r   <= sum_nxt;
    idx_d_r <= tag_in.idx;
    idx_r   <= idx_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      vld_d_r <= tag_in.valid;
      vld_r   <= vld_d_r;
    end
  end

  assign tag_out = '{valid: vld_r, idx: idx_r};
  assign sum_out = sum_r;

endmodule

[rtl/m4mf_round.sv]
// Output stage: floor-shift the exact dot product by FRAC_BITS, saturate
// to a signed WORD_BITS value and register the result word.
module m4mf_round #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  m4mf_pkg::tag_t                     tag_in,
  input  logic signed [2*WORD_BITS+1:0]      sum_in,
  output logic                               out_valid,
  output logic [m4mf_pkg::IDX_W-1:0]         out_product_index,
  output logic signed [m4mf_pkg::PORT_W-1:0] out_product_value,
  output logic                               out_saturated,
  output logic                               out_final_result
);

  localparam int SW = 2 * WORD_BITS + 2;
  localparam int EW = SW + FRAC_BITS;
  localparam int HW = SW - WORD_BITS + 1;
  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [EW-1:0]        ext;
  logic [SW-1:0]        q;
  logic [HW-1:0]        hi;
  logic                 sat_nxt;
  logic [WORD_BITS-1:0] val_nxt;

  logic                         valid_r;
  logic [m4mf_pkg::IDX_W-1:0]   idx_r;
  logic [m4mf_pkg::PORT_W-1:0]  val_r;
  logic                         sat_r;

  // Arithmetic shift right by FRAC_BITS, then range check on the upper bits
  assign ext     = {{FRAC_BITS{sum_in[SW-1]}}, sum_in};
  assign q       = ext[EW-1:FRAC_BITS];
  assign hi      = q[SW-1:WORD_BITS-1];
  assign sat_nxt = !((hi == '0) || (&hi));

  always_comb begin
    if (!sat_nxt) begin
      val_nxt = q[WORD_BITS-1:0];
    end else if (q[SW-1]) begin
      val_nxt = MINV;
    end else begin
      val_nxt = MAXV;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= tag_in.idx;
    sat_r <= sat_nxt;
    val_r <= m4mf_pkg::PORT_W'(signed'(val_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tag_in.valid;
    end
  end

  assign out_valid         = valid_r;
  assign out_product_index = idx_r;
  assign out_product_value = signed'(val_r);
  assign out_saturated     = sat_r;
  assign out_final_result  = valid_r && (idx_r == m4mf_pkg::LAST_IDX);

endmodule

[rtl/matrix4_multiply_fixed.sv]
// Channel  | Handshake            | Data ports
// ---------+----------------------+---------------------------------------------
// input    | start, busy          | in_element_index, in_left_element,
//          |                      | in_right_element, in_load_done
// result   | out_valid (strobe)   | out_product_index, out_product_value,
//          |                      | out_saturated, out_final_result
//
// A load word without in_load_done only stores its elements; busy stays low.
// A word with in_load_done raises busy; sixteen product elements enter the
// four-cell chain one per cycle and pass through the product and sum
// registers of each cell and then the output register. Busy drops at the edge
// that takes the last result word, so no new word is accepted before then.
// Synchronous active-low reset clears the sequencer and the valid bits; the
// stored elements are not cleared. Result words cannot be stalled.
`include "assert_macros.svh"

module matrix4_multiply_fixed #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [m4mf_pkg::IDX_W-1:0]         in_element_index,
  input  logic signed [m4mf_pkg::PORT_W-1:0] in_left_element,
  input  logic signed [m4mf_pkg::PORT_W-1:0] in_right_element,
  input  logic                               in_load_done,
  output logic                               out_valid,
  output logic [m4mf_pkg::IDX_W-1:0]         out_product_index,
  output logic signed [m4mf_pkg::PORT_W-1:0] out_product_value,
  output logic                               out_saturated,
  output logic                               out_final_result
);

  localparam int SW = 2 * WORD_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [m4mf_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                       accept;

  m4mf_pkg::tag_t      tag_c [m4mf_pkg::DIM+1];
  logic signed [SW-1:0] sum_c [m4mf_pkg::DIM+1];

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Sequencer: issue one product element per cycle, then wait for the last word
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_load_done) begin
          state_nxt = ST_ISSUE;
          cnt_nxt   = '0;
        end
      end
      ST_ISSUE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == m4mf_pkg::LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_valid && out_final_result) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Head of the chain: fresh tag, zero partial sum
  assign tag_c[0] = '{valid: (state_r == ST_ISSUE), idx: cnt_r};
  assign sum_c[0] = '0;

  for (genvar k = 0; k < m4mf_pkg::DIM; k++) begin : g_cell
    m4mf_cell #(
      .CELL_K    (k),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (accept),
      .wr_idx   (in_element_index),
      .wr_left  (in_left_element[WORD_BITS-1:0]),
      .wr_right (in_right_element[WORD_BITS-1:0]),
      .tag_in   (tag_c[k]),
      .sum_in   (sum_c[k]),
      .tag_out  (tag_c[k+1]),
      .sum_out  (sum_c[k+1])
    );
  end

  m4mf_round #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk               (clk),
    .rst_n             (rst_n),
    .tag_in            (tag_c[m4mf_pkg::DIM]),
    .sum_in            (sum_c[m4mf_pkg::DIM]),
    .out_valid         (out_valid),
    .out_product_index (out_product_index),
    .out_product_value (out_product_value),
    .out_saturated     (out_saturated),
    .out_final_result  (out_final_result)
  );

  // Checks
  `ASSERT_CLK(a_out_only_busy, clk, rst_n, out_valid |-> busy, "result word while idle")
  `ASSERT_NEXT(a_last_frees, clk, rst_n, out_valid && out_final_result, !busy,
    "busy held after last result word")
  `ASSERT_NEXT(a_done_starts, clk, rst_n, accept && in_load_done, state_r == ST_ISSUE,
    "multiply not started")
  `ASSERT_NEXT(a_issue_ends, clk, rst_n,
    state_r == ST_ISSUE && cnt_r == m4mf_pkg::LAST_IDX, state_r == ST_DRAIN,
    "issue did not stop after sixteen elements")

endmodule
